// File: hw/rtl/gbsq_pkg.sv
// Package for the GF(2) basis span query block: command codes, sequencer
// states and the beat payload types. No dependencies.
package gbsq_pkg;

  localparam int CMD_W     = 2;
  localparam int VEC_IN_W  = 64;
  localparam int TAG_IN_W  = 32;
  localparam int TAG_OUT_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [VEC_IN_W-1:0] vector;
    logic [TAG_IN_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 in_span;
    logic [TAG_OUT_W-1:0] tag_out;
  } out_item_t;

endpackage

// File: hw/rtl/gbsq_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on gbsq_pkg for the payload types.
interface gbsq_in_if;
  import gbsq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbsq_out_if;
  import gbsq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/gbsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gf2_basis_span_query_top.sv
// GF(2) linear basis with tagged rows: insert, span query and clear over one
// command stream. Insert and query walk the basis one row per cycle from the
// highest bit down, through the single read port of the row RAM. A beat is
// accepted, reduced row by row, then handed to the result register once the
// previous result is taken; an insert that finds a free row, or a query that
// hits an empty row, stops early. Clear and unused codes skip the scan. Clear
// drops all per-row valid flags at once, so no clearing pass follows reset.
// Tags wider than the 32-bit input field are held at 32 bits.
// Depends on gbsq_pkg, gbsq_if and gbsq_ram.
module gf2_basis_span_query_top #(
  parameter int VECTOR_BITS = 64,
  parameter int TAG_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbsq_in_if.sink     in_i,
  gbsq_out_if.source  out_o
);
  import gbsq_pkg::*;

  localparam int IdxW = $clog2(VECTOR_BITS);
  localparam int TagW = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int RowW = VECTOR_BITS + TagW;
  localparam logic [IdxW-1:0] TopIdx = IdxW'(VECTOR_BITS - 1);

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic [VECTOR_BITS-1:0] vec_q, vec_d;
  logic [TagW-1:0]        tag_q, tag_d;
  logic [VECTOR_BITS-1:0] row_valid_q, row_valid_d;
  out_item_t              res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  logic                   ram_we;
  logic [IdxW-1:0]        ram_raddr;
  logic [RowW-1:0]        ram_rdata;
  logic [VECTOR_BITS-1:0] row_vec;
  logic [TagW-1:0]        row_tag;
  logic [VECTOR_BITS-1:0] vec_nxt;
  logic [TagW-1:0]        tag_nxt;
  logic                   lead_set;

  gbsq_ram #(
    .Width (RowW),
    .Depth (VECTOR_BITS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({vec_q, tag_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an invalid row reads as empty
  assign row_vec  = row_valid_q[idx_q] ? ram_rdata[RowW-1:TagW] : '0;
  assign row_tag  = row_valid_q[idx_q] ? ram_rdata[TagW-1:0] : '0;
  assign lead_set = vec_q[idx_q];
  assign vec_nxt  = lead_set ? (vec_q ^ row_vec) : vec_q;
  assign tag_nxt  = lead_set ? (tag_q ^ row_tag) : tag_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    vec_d       = vec_q;
    tag_d       = tag_q;
    row_valid_d = row_valid_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_raddr   = TopIdx;
    in_i.ready  = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          cmd_d = in_i.data.cmd;
          res_d = '0;
          case (in_i.data.cmd)
            CMD_CLEAR: begin
              row_valid_d = '0;
              state_d     = ST_FINISH;
            end
            CMD_INSERT: begin
              vec_d   = in_i.data.vector[VECTOR_BITS-1:0];
              tag_d   = in_i.data.tag[TagW-1:0];
              idx_d   = TopIdx;
              state_d = ST_SCAN;
            end
            CMD_QUERY: begin
              vec_d   = in_i.data.vector[VECTOR_BITS-1:0];
              tag_d   = '0;
              idx_d   = TopIdx;
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // fetch the next lower row while this one is reduced
        ram_raddr = idx_q - 1'b1;
        if (lead_set && !row_valid_q[idx_q]) begin
          res_d = '0;
          if (cmd_q == CMD_INSERT) begin
            ram_we              = 1'b1;
            row_valid_d[idx_q]  = 1'b1;
            res_d.accepted      = 1'b1;
          end
          state_d = ST_FINISH;
        end else begin
          vec_d = vec_nxt;
          tag_d = tag_nxt;
          if (idx_q == '0) begin
            res_d = '0;
            if (cmd_q == CMD_QUERY && vec_nxt == '0) begin
              res_d.in_span = 1'b1;
              res_d.tag_out = TAG_OUT_W'(tag_nxt);
            end
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    vec_q      <= vec_d;
    tag_q      <= tag_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: hw/rtl/gbsq_checker.sv
// Port-level checks for gf2_basis_span_query_top, attached by bind.
// Depends on gbsq_pkg for the result tag width.
module gbsq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           out_accepted_i,
  input logic                           out_in_span_i,
  input logic [gbsq_pkg::TAG_OUT_W-1:0] out_tag_i
);
  import gbsq_pkg::*;

  // one beat at a time: busy right after a command is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a command beat");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_accepted_i && out_in_span_i))
    else $error("insert and query flags both set");

  a_tag_zero_outside_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_in_span_i |-> out_tag_i == '0)
    else $error("nonzero tag on a result that is not in span");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_accepted_i)
      && $stable(out_in_span_i) && $stable(out_tag_i))
    else $error("stalled result beat changed");

endmodule

bind gf2_basis_span_query_top gbsq_checker u_gbsq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_accepted_i (out_o.data.accepted),
  .out_in_span_i  (out_o.data.in_span),
  .out_tag_i      (out_o.data.tag_out)
);
